[sv/ccc_pkg.sv]
// Package for the cruise calendar converter: field widths, calendar constants,
// reciprocal constants for the fixed divisions, and the controller/datapath command types.
// No dependencies.
package ccc_pkg;

   // Default span of the calendar window, in years.
   localparam int SPAN_DEFAULT = 5;

   // Payload field widths.
   localparam int SECS_W   = 28;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int SEC_W    = 6;
   localparam int DOY_W    = 9;
   localparam int STATUS_W = 2;

   // Day counts from the start of the window fit in 12 bits for spans of up to 11 years.
   localparam int DAYS_W = 12;
   localparam int REM_W  = 17;

   localparam logic [YEAR_W-1:0] FIRST_YEAR_RESET = 12'd1970;

   // Calendar constants.
   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [8:0]  DAYS_COMMON   = 9'd365;
   localparam logic [6:0]  YEARS_PER_CENT = 7'd100;

   // Reciprocals for division by constants. Each gives a quotient that is exact or one low.
   localparam logic [27:0] RECIP_DAY  = 28'd203613264;   // 2^44 / 86400
   localparam logic [10:0] RECIP_HOUR = 11'd1165;        // 2^22 / 3600
   localparam logic [12:0] RECIP_MIN  = 13'd4369;        // 2^18 / 60
   localparam logic [12:0] RECIP_CENT = 13'd5243;        // 2^19 / 100, exact here

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_SPAN  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FIELD = 2'd2;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_BUILD_Q,
      OP_BUILD_L,
      OP_D_MUL,
      OP_D_BACK,
      OP_D_FIX,
      OP_D_YEAR,
      OP_D_DOY,
      OP_D_MONTH,
      OP_D_MIN,
      OP_E_CHECK,
      OP_E_MUL,
      OP_E_SUM
   } ccc_op_type;

   typedef struct packed {
      ccc_op_type op;
      logic       capture;
      logic       load_out;
   } ccc_cmd_type;

   typedef struct packed {
      logic build_last;
      logic span_err;
      logic date_err;
   } ccc_stat_type;

   // Day of year (from zero) on which month index mi (0 is January) starts.
   function automatic logic [8:0] month_start(input logic [3:0] mi, input logic leap);
      logic [8:0] base;
      case (mi)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + 9'((mi >= 4'd2) && leap);
   endfunction

endpackage

[sv/cruise_calendar_converter.sv]
// Cruise calendar converter: seconds from 1 January of the first year to calendar fields and back.
// Seconds to date runs the multiply, back-multiply, remainder fix, year, day-of-year, month and
// minute steps, ending early on a span error; date to seconds runs the check, multiply and sum
// steps, ending early on an error. The next input can be taken in the cycle after the result
// leaves the work registers. Synchronous reset and every first_year write rebuild the year table
// one year at a time, during which input stays stalled.
module cruise_calendar_converter #(
   parameter int YEARS_SPAN = ccc_pkg::SPAN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [ccc_pkg::SECS_W-1:0]    req_seconds_in,
   input  logic [ccc_pkg::YEAR_W-1:0]    req_year_in,
   input  logic [ccc_pkg::MONTH_W-1:0]   req_month_in,
   input  logic [ccc_pkg::DAY_W-1:0]     req_day_in,
   input  logic [ccc_pkg::HOUR_W-1:0]    req_hour_in,
   input  logic [ccc_pkg::MIN_W-1:0]     req_minute_in,
   input  logic [ccc_pkg::SEC_W-1:0]     req_second_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ccc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ccc_pkg::SECS_W-1:0]    rsp_seconds_out,
   output logic [ccc_pkg::YEAR_W-1:0]    rsp_year_out,
   output logic [ccc_pkg::MONTH_W-1:0]   rsp_month_out,
   output logic [ccc_pkg::DAY_W-1:0]     rsp_day_out,
   output logic [ccc_pkg::HOUR_W-1:0]    rsp_hour_out,
   output logic [ccc_pkg::MIN_W-1:0]     rsp_minute_out,
   output logic [ccc_pkg::SEC_W-1:0]     rsp_second_out,
   output logic [ccc_pkg::DOY_W-1:0]     rsp_day_of_year,
   input  logic                          csr_wr_en,
   input  logic [ccc_pkg::YEAR_W-1:0]    csr_wr_data
);
   import ccc_pkg::*;

   ccc_cmd_type  cmd;
   ccc_stat_type stat;

   // Sequencer and handshakes.
   ccc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_wr_en (csr_wr_en),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Table, arithmetic and output register.
   ccc_datapath #(
      .YEARS_SPAN (YEARS_SPAN)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_seconds_in  (req_seconds_in),
      .req_year_in     (req_year_in),
      .req_month_in    (req_month_in),
      .req_day_in      (req_day_in),
      .req_hour_in     (req_hour_in),
      .req_minute_in   (req_minute_in),
      .req_second_in   (req_second_in),
      .rsp_status      (rsp_status),
      .rsp_seconds_out (rsp_seconds_out),
      .rsp_year_out    (rsp_year_out),
      .rsp_month_out   (rsp_month_out),
      .rsp_day_out     (rsp_day_out),
      .rsp_hour_out    (rsp_hour_out),
      .rsp_minute_out  (rsp_minute_out),
      .rsp_second_out  (rsp_second_out),
      .rsp_day_of_year (rsp_day_of_year)
   );

endmodule

[sv/ccc_datapath.sv]
// Datapath of the cruise calendar converter: year start table, leap flags, the
// conversion registers and the output register. Depends on ccc_pkg.
module ccc_datapath #(
   parameter int YEARS_SPAN = ccc_pkg::SPAN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ccc_pkg::ccc_cmd_type          cmd,
   output ccc_pkg::ccc_stat_type         stat,
   input  logic                          csr_wr_en,
   input  logic [ccc_pkg::YEAR_W-1:0]    csr_wr_data,
   input  logic [ccc_pkg::SECS_W-1:0]    req_seconds_in,
   input  logic [ccc_pkg::YEAR_W-1:0]    req_year_in,
   input  logic [ccc_pkg::MONTH_W-1:0]   req_month_in,
   input  logic [ccc_pkg::DAY_W-1:0]     req_day_in,
   input  logic [ccc_pkg::HOUR_W-1:0]    req_hour_in,
   input  logic [ccc_pkg::MIN_W-1:0]     req_minute_in,
   input  logic [ccc_pkg::SEC_W-1:0]     req_second_in,
   output logic [ccc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ccc_pkg::SECS_W-1:0]    rsp_seconds_out,
   output logic [ccc_pkg::YEAR_W-1:0]    rsp_year_out,
   output logic [ccc_pkg::MONTH_W-1:0]   rsp_month_out,
   output logic [ccc_pkg::DAY_W-1:0]     rsp_day_out,
   output logic [ccc_pkg::HOUR_W-1:0]    rsp_hour_out,
   output logic [ccc_pkg::MIN_W-1:0]     rsp_minute_out,
   output logic [ccc_pkg::SEC_W-1:0]     rsp_second_out,
   output logic [ccc_pkg::DOY_W-1:0]     rsp_day_of_year
);
   import ccc_pkg::*;

   localparam int YO_W = (YEARS_SPAN > 1) ? $clog2(YEARS_SPAN) : 1;
   localparam int YI_W = $clog2(YEARS_SPAN + 1);

   // Configuration and table state.
   logic [YEAR_W-1:0]     first_year_ff;
   logic [YO_W-1:0]       build_idx_ff;
   logic [5:0]            cent_q_ff;
   logic [DAYS_W-1:0]     acc_ff;
   logic [YEARS_SPAN-1:0] leap_ff;
   logic [DAYS_W-1:0]     ys_ff [0:YEARS_SPAN];

   // Captured item.
   logic [SECS_W-1:0]  secs_ff;
   logic [YEAR_W-1:0]  year_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [DAY_W-1:0]   day_ff;
   logic [HOUR_W-1:0]  hour_ff;
   logic [MIN_W-1:0]   minute_ff;
   logic [SEC_W-1:0]   second_ff;

   // Working registers.
   logic [55:0]        prod_ff;
   logic [DAYS_W-1:0]  q0_ff;
   logic [28:0]        back_ff;
   logic [DAYS_W-1:0]  days_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [YO_W-1:0]    yo_ff;
   logic [27:0]        hmul_ff;
   logic [8:0]         doyz_ff;
   logic [4:0]         h0_ff;
   logic [12:0]        rh_ff;
   logic [11:0]        rm_ff;
   logic [24:0]        mmul_ff;
   logic [DAYS_W-1:0]  ndays_ff;
   logic [16:0]        hms_ff;
   logic [28:0]        dsec_ff;

   // Finished result and output register.
   logic [STATUS_W-1:0] res_status_ff, out_status_ff;
   logic [SECS_W-1:0]   res_seconds_ff, out_seconds_ff;
   logic [YEAR_W-1:0]   res_year_ff, out_year_ff;
   logic [MONTH_W-1:0]  res_month_ff, out_month_ff;
   logic [DAY_W-1:0]    res_day_ff, out_day_ff;
   logic [HOUR_W-1:0]   res_hour_ff, out_hour_ff;
   logic [MIN_W-1:0]    res_minute_ff, out_minute_ff;
   logic [SEC_W-1:0]    res_second_ff, out_second_ff;
   logic [DOY_W-1:0]    res_doy_ff, out_doy_ff;

   // Table build: year under test, its century quotient and its leap flag.
   logic [12:0]       build_year;
   logic [25:0]       cent_prod;
   logic              century;
   logic              build_leap;
   logic [DAYS_W-1:0] build_base;
   logic [DAYS_W-1:0] build_next;
   logic [YI_W-1:0]   ys_wr_idx;

   always_comb begin
      build_year = 13'(first_year_ff) + 13'(build_idx_ff);
      cent_prod  = 26'(build_year) * 26'(RECIP_CENT);
      century    = (13'(cent_q_ff) * 13'(YEARS_PER_CENT)) == build_year;
      build_leap = (build_year[1:0] == 2'd0) && (!century || (cent_q_ff[1:0] == 2'd0));
      build_base = (build_idx_ff == '0) ? '0 : acc_ff;
      build_next = build_base + DAYS_W'(DAYS_COMMON) + DAYS_W'(build_leap);
      ys_wr_idx  = YI_W'(build_idx_ff) + YI_W'(1);
   end

   // Date checks and the shared table read port.
   logic [YEAR_W-1:0] yoff;
   logic              year_err;
   logic              field_err;
   logic [YO_W-1:0]   sel_idx;
   logic [DAYS_W-1:0] ys_sel;
   logic              leap_sel;

   always_comb begin
      yoff      = year_ff - first_year_ff;
      year_err  = (year_ff < first_year_ff) || (yoff >= YEAR_W'(YEARS_SPAN));
      field_err = (month_ff == '0) || (month_ff > 4'd12) || (day_ff == '0) ||
                  (hour_ff > 5'd24) || (minute_ff > 6'd60) || (second_ff > 6'd60);
      sel_idx   = (cmd.op == OP_E_CHECK) ? yoff[YO_W-1:0] : yo_ff;
      ys_sel    = ys_ff[YI_W'(sel_idx)];
      leap_sel  = leap_ff[sel_idx];
   end

   // Seconds to date: remainder fix, year search, month search, hour fix, minute split.
   logic [28:0]       day_diff;
   logic [YO_W-1:0]   yo_find;
   logic [3:0]        mi_find;
   logic [8:0]        dom0;
   logic [11:0]       rm_fix;
   logic [4:0]        hour_fix;
   logic [5:0]        m0;
   logic [6:0]        sd;

   always_comb begin
      day_diff = {1'b0, secs_ff} - back_ff;
      yo_find = '0;
      for (int j = 1; j < YEARS_SPAN; j++) begin
         if (ys_ff[j] <= days_ff) begin
            yo_find = YO_W'(j);
         end
      end
      mi_find = '0;
      for (int k = 1; k < 12; k++) begin
         if (month_start(4'(k), leap_sel) <= doyz_ff) begin
            mi_find = 4'(k);
         end
      end
      dom0 = doyz_ff - month_start(mi_find, leap_sel);
      if (rh_ff >= 13'(SECS_PER_HOUR)) begin
         rm_fix   = 12'(rh_ff - 13'(SECS_PER_HOUR));
         hour_fix = h0_ff + 5'd1;
      end else begin
         rm_fix   = 12'(rh_ff);
         hour_fix = h0_ff;
      end
      m0 = mmul_ff[23:18];
      sd = 7'(rm_ff - 12'(m0) * 12'(SECS_PER_MIN));
   end

   assign stat.build_last = (build_idx_ff == YO_W'(YEARS_SPAN - 1));
   assign stat.span_err   = (days_ff >= ys_ff[YEARS_SPAN]);
   assign stat.date_err   = year_err || field_err;

   // Configuration register and table build counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_year_ff <= FIRST_YEAR_RESET;
         build_idx_ff  <= '0;
      end else if (csr_wr_en) begin
         first_year_ff <= csr_wr_data;
         build_idx_ff  <= '0;
      end else if (cmd.op == OP_BUILD_L) begin
         build_idx_ff  <= stat.build_last ? '0 : build_idx_ff + YO_W'(1);
      end
   end

   // Table contents, item capture and the conversion steps.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         secs_ff        <= req_seconds_in;
         year_ff        <= req_year_in;
         month_ff       <= req_month_in;
         day_ff         <= req_day_in;
         hour_ff        <= req_hour_in;
         minute_ff      <= req_minute_in;
         second_ff      <= req_second_in;
         res_status_ff  <= STAT_OK;
         res_seconds_ff <= '0;
         res_year_ff    <= '0;
         res_month_ff   <= '0;
         res_day_ff     <= '0;
         res_hour_ff    <= '0;
         res_minute_ff  <= '0;
         res_second_ff  <= '0;
         res_doy_ff     <= '0;
      end
      case (cmd.op)
         OP_BUILD_Q: begin
            cent_q_ff <= cent_prod[24:19];
         end
         OP_BUILD_L: begin
            if (build_idx_ff == '0) begin
               ys_ff[0] <= '0;
            end
            ys_ff[ys_wr_idx]      <= build_next;
            leap_ff[build_idx_ff] <= build_leap;
            acc_ff                <= build_next;
         end
         OP_D_MUL: begin
            prod_ff <= 56'(secs_ff) * 56'(RECIP_DAY);
         end
         OP_D_BACK: begin
            q0_ff   <= prod_ff[55:44];
            back_ff <= 29'(prod_ff[55:44]) * 29'(SECS_PER_DAY);
         end
         OP_D_FIX: begin
            if (day_diff >= 29'(SECS_PER_DAY)) begin
               days_ff <= q0_ff + DAYS_W'(1);
               rem_ff  <= REM_W'(day_diff - 29'(SECS_PER_DAY));
            end else begin
               days_ff <= q0_ff;
               rem_ff  <= REM_W'(day_diff);
            end
         end
         OP_D_YEAR: begin
            yo_ff   <= yo_find;
            hmul_ff <= 28'(rem_ff) * 28'(RECIP_HOUR);
            if (stat.span_err) begin
               res_status_ff <= STAT_SPAN;
            end
         end
         OP_D_DOY: begin
            doyz_ff <= 9'(days_ff - ys_sel);
            h0_ff   <= hmul_ff[26:22];
            rh_ff   <= 13'(rem_ff - 17'(hmul_ff[26:22]) * 17'(SECS_PER_HOUR));
         end
         OP_D_MONTH: begin
            rm_ff        <= rm_fix;
            mmul_ff      <= 25'(rm_fix) * 25'(RECIP_MIN);
            res_hour_ff  <= hour_fix;
            res_year_ff  <= first_year_ff + YEAR_W'(yo_ff);
            res_month_ff <= mi_find + 4'd1;
            res_day_ff   <= DAY_W'(dom0 + 9'd1);
            res_doy_ff   <= doyz_ff + 9'd1;
         end
         OP_D_MIN: begin
            if (sd >= 7'(SECS_PER_MIN)) begin
               res_minute_ff <= m0 + 6'd1;
               res_second_ff <= 6'(sd - 7'(SECS_PER_MIN));
            end else begin
               res_minute_ff <= m0;
               res_second_ff <= 6'(sd);
            end
         end
         OP_E_CHECK: begin
            ndays_ff <= ys_sel + DAYS_W'(month_start(month_ff - 4'd1, leap_sel)) +
                        DAYS_W'(day_ff) - DAYS_W'(1);
            hms_ff   <= 17'(hour_ff) * 17'(SECS_PER_HOUR) +
                        17'(minute_ff) * 17'(SECS_PER_MIN) + 17'(second_ff);
            if (year_err) begin
               res_status_ff <= STAT_SPAN;
            end else if (field_err) begin
               res_status_ff <= STAT_FIELD;
            end
         end
         OP_E_MUL: begin
            dsec_ff <= 29'(ndays_ff) * 29'(SECS_PER_DAY);
         end
         OP_E_SUM: begin
            res_seconds_ff <= SECS_W'(dsec_ff + 29'(hms_ff));
         end
         default: begin
         end
      endcase
   end

   // Output register, loaded when the controller hands a finished beat over.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff  <= res_status_ff;
         out_seconds_ff <= res_seconds_ff;
         out_year_ff    <= res_year_ff;
         out_month_ff   <= res_month_ff;
         out_day_ff     <= res_day_ff;
         out_hour_ff    <= res_hour_ff;
         out_minute_ff  <= res_minute_ff;
         out_second_ff  <= res_second_ff;
         out_doy_ff     <= res_doy_ff;
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_seconds_out = out_seconds_ff;
   assign rsp_year_out    = out_year_ff;
   assign rsp_month_out   = out_month_ff;
   assign rsp_day_out     = out_day_ff;
   assign rsp_hour_out    = out_hour_ff;
   assign rsp_minute_out  = out_minute_ff;
   assign rsp_second_out  = out_second_ff;
   assign rsp_day_of_year = out_doy_ff;

endmodule

[sv/ccc_ctrl.sv]
// Controller of the cruise calendar converter: sequences table builds and the
// conversion steps, and owns both handshakes. Depends on ccc_pkg.
module ccc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   csr_wr_en,
   output ccc_pkg::ccc_cmd_type   cmd,
   input  ccc_pkg::ccc_stat_type  stat
);
   import ccc_pkg::*;

   typedef enum logic [3:0] {
      ST_BUILD_Q,
      ST_BUILD_L,
      ST_IDLE,
      ST_D_MUL,
      ST_D_BACK,
      ST_D_FIX,
      ST_D_YEAR,
      ST_D_DOY,
      ST_D_MONTH,
      ST_D_MIN,
      ST_E_CHECK,
      ST_E_MUL,
      ST_E_SUM,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   // Input is taken only when idle and no register write is under way.
   assign req_stall = (state_ff != ST_IDLE) || csr_wr_en;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_BUILD_Q: state_in = ST_BUILD_L;
         ST_BUILD_L: state_in = stat.build_last ? ST_IDLE : ST_BUILD_Q;
         ST_IDLE: begin
            if (accept) begin
               state_in = req_cmd ? ST_E_CHECK : ST_D_MUL;
            end
         end
         ST_D_MUL:   state_in = ST_D_BACK;
         ST_D_BACK:  state_in = ST_D_FIX;
         ST_D_FIX:   state_in = ST_D_YEAR;
         ST_D_YEAR:  state_in = stat.span_err ? ST_DONE : ST_D_DOY;
         ST_D_DOY:   state_in = ST_D_MONTH;
         ST_D_MONTH: state_in = ST_D_MIN;
         ST_D_MIN:   state_in = ST_DONE;
         ST_E_CHECK: state_in = stat.date_err ? ST_DONE : ST_E_MUL;
         ST_E_MUL:   state_in = ST_E_SUM;
         ST_E_SUM:   state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
      // A register write restarts the table build.
      if (csr_wr_en) begin
         state_in = ST_BUILD_Q;
      end
   end

   // Datapath command decode.
   always_comb begin
      cmd.capture  = accept;
      cmd.load_out = (state_ff == ST_DONE) && out_free;
      case (state_ff)
         ST_BUILD_Q: cmd.op = OP_BUILD_Q;
         ST_BUILD_L: cmd.op = OP_BUILD_L;
         ST_D_MUL:   cmd.op = OP_D_MUL;
         ST_D_BACK:  cmd.op = OP_D_BACK;
         ST_D_FIX:   cmd.op = OP_D_FIX;
         ST_D_YEAR:  cmd.op = OP_D_YEAR;
         ST_D_DOY:   cmd.op = OP_D_DOY;
         ST_D_MONTH: cmd.op = OP_D_MONTH;
         ST_D_MIN:   cmd.op = OP_D_MIN;
         ST_E_CHECK: cmd.op = OP_E_CHECK;
         ST_E_MUL:   cmd.op = OP_E_MUL;
         ST_E_SUM:   cmd.op = OP_E_SUM;
         default:    cmd.op = OP_NONE;
      endcase
   end

   // The output beat stays valid until taken; a new result replaces it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BUILD_Q;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Only one item is in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while an item was in work");

   // A finished result moves to the output register once it is free.
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free && !csr_wr_en) |=>
      (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished result not delivered to the output register");

   // The output beat is dropped only when it was taken.
   a_drop_taken: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(!rsp_stall))
      else $error("output beat lost while stalled");

endmodule
